// ===== rtl/tri_area_pkg.sv =====
`timescale 1ns / 1ps

package tri_area_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_W      = COORD_BITS + 1;        // edge vector component
  localparam int PROD_W      = 2 * DIFF_W;            // one cross-product term
  localparam int CROSS_W     = PROD_W + 1;            // difference of two terms
  localparam int MAG_W       = 2 * COORD_BITS + 2;    // |w| never exceeds 2^(2*COORD_BITS+1)
  localparam int HALF_W      = MAG_W / 2;             // split of |w| for squaring
  localparam int SUM_W       = 2 * MAG_W;             // sum of three squares
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int AREA_W      = 34;
  localparam int SQRT_BITS   = 2;                     // root bits resolved per stage
  localparam int SQRT_STAGES = ROOT_W / SQRT_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } tri_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_step_t;

endpackage

// ===== rtl/tri_area_cross.sv =====
`timescale 1ns / 1ps

module tri_area_cross (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  tri_valid,
  input  tri_area_pkg::tri_t    tri_in,
  output logic                  mag_valid,
  output tri_area_pkg::mag3_t   mag
);

  localparam int DW = tri_area_pkg::DIFF_W;
  localparam int PW = tri_area_pkg::PROD_W;
  localparam int CW = tri_area_pkg::CROSS_W;
  localparam int MW = tri_area_pkg::MAG_W;
  localparam int CB = tri_area_pkg::COORD_BITS;

  logic                 v1_r, v2_r, v3_r;
  logic signed [DW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [DW-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [PW-1:0] p_r [6];
  logic signed [PW-1:0] p_nxt [6];
  logic signed [CW-1:0] w_nxt [3];
  logic        [CW-1:0] neg_w [3];
  tri_area_pkg::mag3_t  mag_r, mag_nxt;

  // edge vectors B-A and C-A, sign-extended by one bit
  always_comb begin
    ux_nxt = {tri_in.bx[CB-1], tri_in.bx} - {tri_in.ax[CB-1], tri_in.ax};
    uy_nxt = {tri_in.by[CB-1], tri_in.by} - {tri_in.ay[CB-1], tri_in.ay};
    uz_nxt = {tri_in.bz[CB-1], tri_in.bz} - {tri_in.az[CB-1], tri_in.az};
    vx_nxt = {tri_in.cx[CB-1], tri_in.cx} - {tri_in.ax[CB-1], tri_in.ax};
    vy_nxt = {tri_in.cy[CB-1], tri_in.cy} - {tri_in.ay[CB-1], tri_in.ay};
    vz_nxt = {tri_in.cz[CB-1], tri_in.cz} - {tri_in.az[CB-1], tri_in.az};
  end

  always_comb begin
    p_nxt[0] = uy_r * vz_r;
    p_nxt[1] = uz_r * vy_r;
    p_nxt[2] = uz_r * vx_r;
    p_nxt[3] = ux_r * vz_r;
    p_nxt[4] = ux_r * vy_r;
    p_nxt[5] = uy_r * vx_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_nxt[k] = {p_r[2*k][PW-1], p_r[2*k]} - {p_r[2*k+1][PW-1], p_r[2*k+1]};
      neg_w[k] = CW'(0) - w_nxt[k];
      mag_nxt[k] = w_nxt[k][CW-1] ? neg_w[k][MW-1:0] : w_nxt[k][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= tri_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      uz_r <= uz_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      vz_r <= vz_nxt;
      for (int k = 0; k < 6; k++) begin
        p_r[k] <= p_nxt[k];
      end
      mag_r <= mag_nxt;
    end
  end

  assign mag_valid = v3_r;
  assign mag       = mag_r;

endmodule

// ===== rtl/tri_area_square.sv =====
`timescale 1ns / 1ps

module tri_area_square (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              mag_valid,
  input  tri_area_pkg::mag3_t               mag,
  output logic                              sum_valid,
  output logic [tri_area_pkg::SUM_W-1:0]    sum
);

  localparam int HW = tri_area_pkg::HALF_W;
  localparam int PW = tri_area_pkg::PROD_W;
  localparam int SW = tri_area_pkg::SUM_W;

  logic          v4_r, v5_r, v6_r;
  logic [PW-1:0] hh_r [3];
  logic [PW-1:0] hl_r [3];
  logic [PW-1:0] ll_r [3];
  logic [PW-1:0] hh_nxt [3];
  logic [PW-1:0] hl_nxt [3];
  logic [PW-1:0] ll_nxt [3];
  logic [SW-1:0] sq_r [3];
  logic [SW-1:0] sq_nxt [3];
  logic [SW-1:0] sum_r, sum_nxt;

  // |w| = h*2^HW + l; square from three narrow partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = PW'(mag[k][2*HW-1:HW]) * PW'(mag[k][2*HW-1:HW]);
      hl_nxt[k] = PW'(mag[k][2*HW-1:HW]) * PW'(mag[k][HW-1:0]);
      ll_nxt[k] = PW'(mag[k][HW-1:0])    * PW'(mag[k][HW-1:0]);
      sq_nxt[k] = (SW'(hh_r[k]) << (2 * HW)) + (SW'(hl_r[k]) << (HW + 1))
                + SW'(ll_r[k]);
    end
    sum_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= mag_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= hh_nxt[k];
        hl_r[k] <= hl_nxt[k];
        ll_r[k] <= ll_nxt[k];
        sq_r[k] <= sq_nxt[k];
      end
      sum_r <= sum_nxt;
    end
  end

  assign sum_valid = v6_r;
  assign sum       = sum_r;

endmodule

// ===== rtl/tri_area_isqrt.sv =====
`timescale 1ns / 1ps

module tri_area_isqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              sum_valid,
  input  logic [tri_area_pkg::SUM_W-1:0]    sum,
  output logic                              root_valid,
  output logic [tri_area_pkg::ROOT_W-1:0]   root
);

  localparam int NS = tri_area_pkg::SQRT_STAGES;
  localparam int NB = tri_area_pkg::SQRT_BITS;
  localparam int SW = tri_area_pkg::SUM_W;
  localparam int RW = tri_area_pkg::ROOT_W;
  localparam int MW = tri_area_pkg::REM_W;

  // one restoring step: bring down two radicand bits, try root bit 1
  function automatic tri_area_pkg::sqrt_step_t sqrt_step(
    input logic [MW-1:0] rem,
    input logic [RW-1:0] q,
    input logic [1:0]    dd
  );
    logic [MW+1:0]              rs;
    logic [MW+1:0]              trial;
    tri_area_pkg::sqrt_step_t   s;
    rs    = {rem, dd};
    trial = {{(MW-RW){1'b0}}, q, 2'b01};
    if (rs >= trial) begin
      s.rem  = MW'(rs - trial);
      s.root = {q[RW-2:0], 1'b1};
    end else begin
      s.rem  = MW'(rs);
      s.root = {q[RW-2:0], 1'b0};
    end
    return s;
  endfunction

  logic          vld_r [NS];
  logic [RW-1:0] q_r   [NS];
  logic [MW-1:0] rem_r [NS];
  logic [SW-1:0] d_r   [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic                       v_in;
    logic [RW-1:0]              q_in;
    logic [MW-1:0]              rem_in;
    logic [SW-1:0]              d_in;
    tri_area_pkg::sqrt_step_t   s0, s1;

    if (g == 0) begin : g_first
      assign v_in   = sum_valid;
      assign q_in   = '0;
      assign rem_in = '0;
      assign d_in   = sum;
    end else begin : g_next
      assign v_in   = vld_r[g-1];
      assign q_in   = q_r[g-1];
      assign rem_in = rem_r[g-1];
      assign d_in   = d_r[g-1];
    end

    always_comb begin
      s0 = sqrt_step(rem_in, q_in, d_in[SW-1 -: 2]);
      s1 = sqrt_step(s0.rem, s0.root, d_in[SW-3 -: 2]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[g]   <= s1.root;
        rem_r[g] <= s1.rem;
        d_r[g]   <= d_in << (2 * NB);
      end
    end
  end

  assign root_valid = vld_r[NS-1];
  assign root       = q_r[NS-1];

endmodule

// ===== rtl/triangle_area_3d.sv =====
`timescale 1ns / 1ps

// Twice the area of a 3D triangle: floor(|(B-A) x (C-A)|).
//
// Input channel: in_valid / in_stall with the nine signed vertex coordinates
// in_vertex_{a,b,c}_{x,y,z}. An item is taken on a clock edge where in_valid
// is high and in_stall is low. Result channel: out_valid / out_stall with
// out_double_area, taken on an edge where out_valid is high and out_stall low.
//
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// Pipeline: 6 stages of edge vectors, cross product and squaring, 17 stages
// of square root at two root bits per stage, one output register.
//
// When the receiver stalls, the result held on the output stays put and one
// further result parks in a skid register; in_stall then rises and the whole
// pipeline freezes until the output is taken. No item is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and the output; the
// block takes items from the first cycle after reset.
module triangle_area_3d (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tri_area_pkg::coord_t              in_vertex_a_x,
  input  tri_area_pkg::coord_t              in_vertex_a_y,
  input  tri_area_pkg::coord_t              in_vertex_a_z,
  input  tri_area_pkg::coord_t              in_vertex_b_x,
  input  tri_area_pkg::coord_t              in_vertex_b_y,
  input  tri_area_pkg::coord_t              in_vertex_b_z,
  input  tri_area_pkg::coord_t              in_vertex_c_x,
  input  tri_area_pkg::coord_t              in_vertex_c_y,
  input  tri_area_pkg::coord_t              in_vertex_c_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tri_area_pkg::AREA_W-1:0]   out_double_area
);

  localparam int AW = tri_area_pkg::AREA_W;

  tri_area_pkg::tri_t                   tri_in;
  tri_area_pkg::mag3_t                  mag;
  logic                                 mag_valid;
  logic                                 sum_valid;
  logic [tri_area_pkg::SUM_W-1:0]       sum;
  logic                                 root_valid;
  logic [tri_area_pkg::ROOT_W-1:0]      root;
  logic                                 adv;
  logic                                 take;
  logic                                 out_valid_r, skid_valid_r;
  logic [AW-1:0]                        out_area_r, skid_area_r;

  assign tri_in = '{ax: in_vertex_a_x, ay: in_vertex_a_y, az: in_vertex_a_z,
                    bx: in_vertex_b_x, by: in_vertex_b_y, bz: in_vertex_b_z,
                    cx: in_vertex_c_x, cy: in_vertex_c_y, cz: in_vertex_c_z};

  // pipeline moves whenever the skid register is free
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  tri_area_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tri_valid (in_valid),
    .tri_in    (tri_in),
    .mag_valid (mag_valid),
    .mag       (mag)
  );

  tri_area_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .mag_valid (mag_valid),
    .mag       (mag),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  tri_area_isqrt u_isqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .root_valid (root_valid),
    .root       (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (root_valid) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_area_r <= skid_area_r;
      end
    end else if (root_valid) begin
      if (out_valid_r && !take) begin
        skid_area_r <= AW'(root);
      end else begin
        out_area_r <= AW'(root);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_double_area = out_area_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the output is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_skid_drains_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && out_area_r == $past(skid_area_r))
    else $error("skid item not moved to the output");
`endif

endmodule
